// ===== sv/pdm_pkg.sv =====
package pdm_pkg;

    // Field and state widths
    localparam int POS_W  = 21;
    localparam int DIST_W = 19;
    localparam int MAXP_W = 15;
    localparam int GAIN_W = 16;
    localparam int TOL_W  = 16;
    localparam int PWR_W  = 16;
    localparam int ERR_W  = 23;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIST_W;

    // Register reset values
    localparam logic [DIST_W-1:0] RST_MOVE_DISTANCE = '0;
    localparam logic [MAXP_W-1:0] RST_MAX_POWER     = 15'd16384;
    localparam logic [GAIN_W-1:0] RST_P_GAIN        = 16'd2949;
    localparam logic [GAIN_W-1:0] RST_D_GAIN        = 16'd2621;
    localparam logic [TOL_W-1:0]  RST_DONE_TOL      = 16'd512;
    localparam logic [TOL_W-1:0]  RST_STALL_STEP    = 16'd512;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOVE_DISTANCE  = 3'd0,
        REG_MAX_POWER      = 3'd1,
        REG_P_GAIN         = 3'd2,
        REG_D_GAIN         = 3'd3,
        REG_DONE_TOLERANCE = 3'd4,
        REG_STALL_STEP     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [DIST_W-1:0] move_distance;
        logic [MAXP_W-1:0]        max_power;
        logic [GAIN_W-1:0]        p_gain;
        logic [GAIN_W-1:0]        d_gain;
        logic [TOL_W-1:0]         done_tolerance;
        logic [TOL_W-1:0]         stall_step;
    } t_cfg;

    // Error stage to power stage: errors plus which results the beat makes
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] derr;
        logic                    pwr;    // first result carries computed power
        logic                    fin;    // a done result follows (or is the only one)
        logic                    stall;
    } t_law_beat;

endpackage

// ===== sv/pdm_in_if.sv =====
interface pdm_in_if;
    import pdm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [0:0]              command;
    logic signed [POS_W-1:0] left_position;
    logic signed [POS_W-1:0] right_position;

    modport source (output valid, command, left_position, right_position, input ready);
    modport sink   (input valid, command, left_position, right_position, output ready);

endinterface

// ===== sv/pdm_out_if.sv =====
interface pdm_out_if;
    import pdm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PWR_W-1:0] drive_power;
    logic [0:0]              move_done;
    logic [0:0]              stalled;

    modport source (output valid, drive_power, move_done, stalled, input ready);
    modport sink   (input valid, drive_power, move_done, stalled, output ready);

endinterface

// ===== sv/pdm_error_stage.sv =====
module pdm_error_stage
    import pdm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    pdm_in_if.sink    i_in,
    output logic      o_valid,
    output t_law_beat o_beat,
    input  logic      i_take
);

    // Input register: command and averaged position
    logic                    r_v0;
    logic [0:0]              r_cmd0;
    logic signed [POS_W-1:0] r_avg0;
    logic signed [POS_W:0]   pos_sum;

    // Move state; last_avg stands for target - previous_error
    logic                    r_moving;
    logic signed [ERR_W-1:0] r_target;
    logic signed [POS_W-1:0] r_last_avg;
    logic                    n_moving;
    logic signed [ERR_W-1:0] n_target;
    logic signed [POS_W-1:0] n_last_avg;

    // Result register toward the power stage
    logic      r_v1;
    t_law_beat r_beat;
    logic      n_v1;
    t_law_beat n_beat;

    logic free1;
    logic leave0;
    logic is_tick;

    logic signed [ERR_W-1:0] avg_x;
    logic signed [ERR_W-1:0] last_x;
    logic signed [ERR_W-1:0] dist_x;
    logic signed [ERR_W-1:0] tol_x;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] derr;
    logic [ERR_W-1:0]        err_abs;
    logic [ERR_W-1:0]        derr_abs;
    logic [DIST_W-1:0]       dist_abs;
    logic                    stall;
    logic                    done;
    logic                    short_move;

    assign free1    = !r_v1 || i_take;
    assign leave0   = r_v0 && free1;
    assign i_in.ready = !r_v0 || free1;
    assign is_tick  = (r_cmd0 == CMD_TICK);

    // Floor average of the two drive positions
    assign pos_sum = {i_in.left_position[POS_W-1], i_in.left_position}
                   + {i_in.right_position[POS_W-1], i_in.right_position};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_in.ready) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd0 <= i_in.command;
            r_avg0 <= pos_sum[POS_W:1];
        end
    end

    // Error, error change and the end-of-move tests
    always_comb begin
        avg_x    = {{(ERR_W-POS_W){r_avg0[POS_W-1]}}, r_avg0};
        last_x   = {{(ERR_W-POS_W){r_last_avg[POS_W-1]}}, r_last_avg};
        dist_x   = {{(ERR_W-DIST_W){i_cfg.move_distance[DIST_W-1]}}, i_cfg.move_distance};
        tol_x    = $signed({{(ERR_W-TOL_W){1'b0}}, i_cfg.done_tolerance});
        err      = r_target - avg_x;
        derr     = last_x - avg_x;
        err_abs  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        derr_abs = derr[ERR_W-1] ? ERR_W'(-derr) : ERR_W'(derr);
        dist_abs = i_cfg.move_distance[DIST_W-1] ? DIST_W'(-i_cfg.move_distance)
                                                 : DIST_W'(i_cfg.move_distance);
        stall    = (derr_abs < {{(ERR_W-TOL_W){1'b0}}, i_cfg.stall_step})
                && ({err_abs, 1'b0} < {{(ERR_W+1-DIST_W){1'b0}}, dist_abs});
        done     = (dist_x == '0)
                || (!dist_x[ERR_W-1] && (err <= tol_x))
                || (dist_x[ERR_W-1] && (err >= -tol_x))
                || stall;
        short_move = ({{(DIST_W-TOL_W){1'b0}}, i_cfg.done_tolerance} >= dist_abs);
    end

    // State update and beat decode
    always_comb begin
        n_moving   = r_moving;
        n_target   = r_target;
        n_last_avg = r_last_avg;
        n_v1       = r_v1 && !i_take;
        n_beat     = r_beat;
        if (leave0) begin
            n_v1        = 1'b0;
            n_beat.err  = err;
            n_beat.derr = derr;
            if (!is_tick) begin
                n_target   = avg_x + dist_x;
                n_last_avg = r_avg0;
                n_moving   = !short_move;
                n_v1       = short_move;
                n_beat.pwr   = 1'b0;
                n_beat.fin   = 1'b1;
                n_beat.stall = 1'b0;
            end else if (r_moving) begin
                n_last_avg = r_avg0;
                n_moving   = !done;
                n_v1       = 1'b1;
                n_beat.pwr   = 1'b1;
                n_beat.fin   = done;
                n_beat.stall = stall;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving   <= 1'b0;
            r_target   <= '0;
            r_last_avg <= '0;
            r_v1       <= 1'b0;
        end else begin
            r_moving   <= n_moving;
            r_target   <= n_target;
            r_last_avg <= n_last_avg;
            r_v1       <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_v1;
    assign o_beat  = r_beat;

    // A beat without a power result is the lone stop of a short start
    a_lone_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !r_beat.pwr) |-> (r_beat.fin && !r_beat.stall))
        else $error("stop-only beat malformed");

    // A tick that ends the move leaves the block idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (leave0 && is_tick && r_moving && done) |=> !r_moving)
        else $error("move still active after final tick");

    // Stall only reported together with an end of move
    a_stall_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_beat.stall) |-> r_beat.fin)
        else $error("stall without end of move");

endmodule

// ===== sv/pdm_power_stage.sv =====
module pdm_power_stage
    import pdm_pkg::*;
#(
    parameter int POSITION_FRAC_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_law_beat i_beat,
    output logic      o_take,
    pdm_out_if.source o_res
);

    localparam int SHIFT  = POSITION_FRAC_BITS + 2;
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int SUM_W  = PROD_W + 1;

    // Product stage
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod_p;
    logic signed [PROD_W-1:0] r_prod_d;
    logic                     r_pwr2;
    logic                     r_fin2;
    logic                     r_stall2;

    // Output register with one pending stop result
    logic                    r_ov;
    logic signed [PWR_W-1:0] r_opwr;
    logic                    r_odone;
    logic                    r_ostall;
    logic                    r_pend;
    logic                    r_pstall;

    logic                    free_out;
    logic                    load;
    logic                    fire;
    logic signed [PROD_W-1:0] sh_p;
    logic signed [PROD_W-1:0] sh_d;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim_x;
    logic signed [SUM_W-1:0]  clamped;

    assign fire     = r_ov && o_res.ready;
    assign free_out = !r_ov || (o_res.ready && !r_pend);
    assign load     = r_v2 && free_out;
    assign o_take   = !r_v2 || free_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_take) begin
            r_v2 <= i_valid;
        end
    end

    // Gain products, one multiplier each
    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_prod_p <= $signed({1'b0, i_cfg.p_gain}) * i_beat.err;
            r_prod_d <= $signed({1'b0, i_cfg.d_gain}) * i_beat.derr;
            r_pwr2   <= i_beat.pwr;
            r_fin2   <= i_beat.fin;
            r_stall2 <= i_beat.stall;
        end
    end

    // Floor shift, sum and clamp to the power limit
    always_comb begin
        sh_p  = r_prod_p >>> SHIFT;
        sh_d  = r_prod_d >>> SHIFT;
        sum   = {sh_p[PROD_W-1], sh_p} + {sh_d[PROD_W-1], sh_d};
        lim_x = $signed({{(SUM_W-MAXP_W){1'b0}}, i_cfg.max_power});
        if (sum > lim_x) begin
            clamped = lim_x;
        end else if (sum < -lim_x) begin
            clamped = -lim_x;
        end else begin
            clamped = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else if (load) begin
            r_ov   <= 1'b1;
            r_pend <= r_pwr2 && r_fin2;
        end else if (fire && r_pend) begin
            r_pend <= 1'b0;
        end else if (fire) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pwr2) begin
                r_opwr   <= clamped[PWR_W-1:0];
                r_odone  <= 1'b0;
                r_ostall <= 1'b0;
            end else begin
                r_opwr   <= '0;
                r_odone  <= 1'b1;
                r_ostall <= r_stall2;
            end
            r_pstall <= r_stall2;
        end else if (fire && r_pend) begin
            r_opwr   <= '0;
            r_odone  <= 1'b1;
            r_ostall <= r_pstall;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.drive_power = r_opwr;
    assign o_res.move_done   = r_odone;
    assign o_res.stalled     = r_ostall;

    // A pending stop result always sits behind a shown power beat
    a_pend_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_ov && !r_odone))
        else $error("pending stop without power beat");

    // The stop result follows its power beat directly
    a_stop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_pend) |=> (r_ov && r_odone && r_opwr == '0))
        else $error("stop result not next");

    // Stop results carry zero power
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_odone) |-> (r_opwr == '0))
        else $error("stop result with nonzero power");

endmodule

// ===== sv/pd_distance_move_with_stall_detect_unit.sv =====
// Channel   Dir  Role    Payload
// i_in      in   sink    command, left_position, right_position
// o_out     out  source  drive_power, move_done, stalled
// cfg       in   write   i_cfg_wr_en, i_cfg_index, i_cfg_wdata
//
// A beat's first result passes through the input register, the error stage (state update),
// the product stage and the output register.
// One beat per cycle is accepted while the output is not stalled; a tick that ends a move
// holds the output register for its power and stop results, so that also limits the rate.
// Starts that begin a move and ticks while idle make no result and leave as bubbles.
// Synchronous active-low reset clears move state, configuration registers and all valid flags.
// A stalled output holds the pipeline from the output register back to i_in.ready.
module pd_distance_move_with_stall_detect_unit
    import pdm_pkg::*;
#(
    parameter int POSITION_FRAC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pdm_in_if.sink                i_in,
    pdm_out_if.source             o_out
);

    t_cfg      r_cfg;
    logic      law_valid;
    t_law_beat law_beat;
    logic      law_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_distance  <= RST_MOVE_DISTANCE;
            r_cfg.max_power      <= RST_MAX_POWER;
            r_cfg.p_gain         <= RST_P_GAIN;
            r_cfg.d_gain         <= RST_D_GAIN;
            r_cfg.done_tolerance <= RST_DONE_TOL;
            r_cfg.stall_step     <= RST_STALL_STEP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MOVE_DISTANCE:  r_cfg.move_distance  <= i_cfg_wdata[DIST_W-1:0];
                REG_MAX_POWER:      r_cfg.max_power      <= i_cfg_wdata[MAXP_W-1:0];
                REG_P_GAIN:         r_cfg.p_gain         <= i_cfg_wdata[GAIN_W-1:0];
                REG_D_GAIN:         r_cfg.d_gain         <= i_cfg_wdata[GAIN_W-1:0];
                REG_DONE_TOLERANCE: r_cfg.done_tolerance <= i_cfg_wdata[TOL_W-1:0];
                REG_STALL_STEP:     r_cfg.stall_step     <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    pdm_error_stage u_error (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (law_valid),
        .o_beat  (law_beat),
        .i_take  (law_take)
    );

    pdm_power_stage #(
        .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
    ) u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (law_valid),
        .i_beat  (law_beat),
        .o_take  (law_take),
        .o_res   (o_out)
    );

endmodule

// ===== tb/pdm_drive_checker.sv =====
`timescale 1ns / 100ps

module pdm_drive_checker
    import pdm_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pdm_in_if                     i_cmd_ch,
    pdm_out_if                    i_res_ch,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int PROD_SHIFT = FRAC_BITS + 2;

    typedef struct packed {
        logic signed [PWR_W-1:0] drive_power;
        logic                    move_done;
        logic                    stalled;
    } t_drive_result;

    // Shadow copy of the registers
    logic signed [DIST_W-1:0] move_dist_q;
    logic [MAXP_W-1:0]        max_pwr_q;
    logic [GAIN_W-1:0]        p_gain_q;
    logic [GAIN_W-1:0]        d_gain_q;
    logic [TOL_W-1:0]         done_tol_q;
    logic [TOL_W-1:0]         stall_step_q;

    // Controller state
    bit     moving_q;
    longint target_q;
    longint prev_err_q;

    t_drive_result pending_drive_q[$];

    function automatic t_drive_result drive_result(logic signed [PWR_W-1:0] pwr,
                                                   logic done, logic stall);
        t_drive_result r;
        r.drive_power = pwr;
        r.move_done   = done;
        r.stalled     = stall;
        return r;
    endfunction

    // PD law for one accepted beat; queues the results it should make
    task automatic compute_drive_results(input logic cmd,
                                         input logic signed [POS_W-1:0] lpos,
                                         input logic signed [POS_W-1:0] rpos);
        longint lv, rv, avg, travel, tol, lim, pg, dg, step;
        longint err, derr, pwr, mag_e, mag_de, mag_d, remaining;
        bit stall;
        lv     = lpos;
        rv     = rpos;
        avg    = (lv + rv) >>> 1;
        travel = move_dist_q;
        tol    = done_tol_q;
        lim    = max_pwr_q;
        pg     = p_gain_q;
        dg     = d_gain_q;
        step   = stall_step_q;
        mag_d  = (travel < 0) ? -travel : travel;

        if (cmd == CMD_START) begin
            target_q   = avg + travel;
            prev_err_q = travel;
            moving_q   = (mag_d > tol);
            if (!moving_q)
                pending_drive_q.push_back(drive_result('0, 1'b1, 1'b0));
        end else if (moving_q) begin
            err  = target_q - avg;
            derr = err - prev_err_q;
            pwr  = ((pg * err) >>> PROD_SHIFT) + ((dg * derr) >>> PROD_SHIFT);
            if (pwr > lim)
                pwr = lim;
            else if (pwr < -lim)
                pwr = -lim;
            mag_e  = (err < 0) ? -err : err;
            mag_de = (derr < 0) ? -derr : derr;
            stall  = (mag_de < step) && (2 * mag_e < mag_d);
            prev_err_q = err;
            pending_drive_q.push_back(drive_result(pwr[PWR_W-1:0], 1'b0, 1'b0));

            // remaining error measured along the direction of travel
            if (travel > 0)
                remaining = err;
            else if (travel < 0)
                remaining = -err;
            else
                remaining = 0;
            if (travel == 0 || remaining <= tol || stall) begin
                moving_q = 1'b0;
                pending_drive_q.push_back(drive_result('0, 1'b1, stall));
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_drive_result want;
        if (!i_rst_n) begin
            move_dist_q  = RST_MOVE_DISTANCE;
            max_pwr_q    = RST_MAX_POWER;
            p_gain_q     = RST_P_GAIN;
            d_gain_q     = RST_D_GAIN;
            done_tol_q   = RST_DONE_TOL;
            stall_step_q = RST_STALL_STEP;
            moving_q     = 1'b0;
            target_q     = 0;
            prev_err_q   = 0;
            pending_drive_q.delete();
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MOVE_DISTANCE:  move_dist_q  = i_cfg_wdata;
                    REG_MAX_POWER:      max_pwr_q    = i_cfg_wdata[MAXP_W-1:0];
                    REG_P_GAIN:         p_gain_q     = i_cfg_wdata[GAIN_W-1:0];
                    REG_D_GAIN:         d_gain_q     = i_cfg_wdata[GAIN_W-1:0];
                    REG_DONE_TOLERANCE: done_tol_q   = i_cfg_wdata[TOL_W-1:0];
                    REG_STALL_STEP:     stall_step_q = i_cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end

            // result beat against oldest expectation
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (pending_drive_q.size() == 0) begin
                    $error("unexpected result beat: drive_power %0d move_done %0d stalled %0d",
                           i_res_ch.drive_power, i_res_ch.move_done, i_res_ch.stalled);
                    o_fail_count++;
                end else begin
                    want = pending_drive_q.pop_front();
                    if (i_res_ch.drive_power !== want.drive_power) begin
                        $error("drive_power: expected %0d, actual %0d",
                               want.drive_power, i_res_ch.drive_power);
                        o_fail_count++;
                    end
                    if (i_res_ch.move_done !== want.move_done) begin
                        $error("move_done: expected %0d, actual %0d",
                               want.move_done, i_res_ch.move_done);
                        o_fail_count++;
                    end
                    if (i_res_ch.stalled !== want.stalled) begin
                        $error("stalled: expected %0d, actual %0d",
                               want.stalled, i_res_ch.stalled);
                        o_fail_count++;
                    end
                end
            end

            // command beat
            if (i_cmd_ch.valid && i_cmd_ch.ready)
                compute_drive_results(i_cmd_ch.command, i_cmd_ch.left_position,
                                      i_cmd_ch.right_position);
        end
        o_pending = pending_drive_q.size();
    end

endmodule

// ===== tb/pd_distance_move_with_stall_detect_unit_tb.sv =====
`timescale 1ns / 100ps

module pd_distance_move_with_stall_detect_unit_tb;
    import pdm_pkg::*;

    localparam int FRAC_BITS   = 10;
    localparam int POS_MIN     = -1048576;
    localparam int POS_MAX     = 1048575;
    localparam int ITEM_TARGET = 1050;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending_cnt;
    int idle_pct;
    int stall_pct;
    int cur_dist;
    int cur_tol;
    int items_sent;

    pdm_in_if  cmd_ch();
    pdm_out_if res_ch();

    pd_distance_move_with_stall_detect_unit #(
        .POSITION_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (cmd_ch),
        .o_out       (res_ch)
    );

    pdm_drive_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_cmd_ch     (cmd_ch),
        .i_res_ch     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int clamp_pos(int v);
        if (v < POS_MIN)
            return POS_MIN;
        if (v > POS_MAX)
            return POS_MAX;
        return v;
    endfunction

    // One command beat; returns at the accepting edge with valid still high
    task automatic send_beat(input t_cmd cmd, input int lpos, input int rpos);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid          = 1'b1;
        cmd_ch.command        = cmd;
        cmd_ch.left_position  = lpos[POS_W-1:0];
        cmd_ch.right_position = rpos[POS_W-1:0];
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // Drop valid and let every result drain, plus bubbles still in flight
    task automatic settle_block();
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
        if (idx == REG_MOVE_DISTANCE)
            cur_dist = value;
        if (idx == REG_DONE_TOLERANCE)
            cur_tol = value;
    endtask

    // New limits, gains and thresholds; block must be settled
    task automatic shuffle_gains();
        int mp, pg, dg, tol, stp;
        case ($urandom_range(3))
            0:       mp = 0;
            1:       mp = 16384;
            2:       mp = 32767;
            default: mp = $urandom_range(32767);
        endcase
        case ($urandom_range(5))
            0:       pg = 0;
            1:       pg = 65535;
            default: pg = $urandom_range(8000);
        endcase
        case ($urandom_range(5))
            0:       dg = 0;
            1:       dg = 65535;
            default: dg = $urandom_range(8000);
        endcase
        case ($urandom_range(9))
            0:       tol = 0;
            1:       tol = 65535;
            default: tol = $urandom_range(2048);
        endcase
        case ($urandom_range(7))
            0:       stp = 0;
            1:       stp = 65535;
            default: stp = $urandom_range(4000);
        endcase
        write_reg(REG_MAX_POWER, mp);
        write_reg(REG_P_GAIN, pg);
        write_reg(REG_D_GAIN, dg);
        write_reg(REG_DONE_TOLERANCE, tol);
        write_reg(REG_STALL_STEP, stp);
    endtask

    // Start plus a run of ticks that close in on the target, stick or overshoot
    task automatic drive_move();
        int travel, base, skew, target, avg, gap, frac, nudge, n_ticks;
        if ($urandom_range(2) == 0) begin
            case ($urandom_range(9))
                0:       travel = 262143;
                1:       travel = -262144;
                2:       travel = 0;
                3:       travel = $urandom_range(cur_tol);
                default: travel = $urandom_range(60000);
            endcase
            if (travel != 262143 && travel != -262144 && $urandom_range(1))
                travel = -travel;
            settle_block();
            write_reg(REG_MOVE_DISTANCE, travel);
        end
        base = $urandom_range(1600000);
        base = base - 800000;
        skew = $urandom_range(64);
        skew = skew - 32;
        send_beat(CMD_START, base + skew, base - skew);
        items_sent++;

        target  = base + cur_dist;
        avg     = base;
        n_ticks = $urandom_range(16, 2);
        repeat (n_ticks) begin
            case ($urandom_range(9))
                0, 1: ;                         // robot stuck
                2: begin
                    nudge = $urandom_range(600);
                    avg   = avg + nudge - 300;
                end
                default: begin
                    gap  = target - avg;
                    frac = $urandom_range(10, 2);
                    avg  = avg + gap * frac / 8;
                end
            endcase
            skew = $urandom_range(64);
            skew = skew - 32;
            send_beat(CMD_TICK, clamp_pos(avg + skew), clamp_pos(avg - skew));
            items_sent++;
        end
    endtask

    // Stimulus
    initial begin
        int moves, phase;
        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = CMD_START;
        cmd_ch.left_position  = '0;
        cmd_ch.right_position = '0;
        idle_pct              = 0;
        stall_pct             = 0;
        cur_dist              = 0;
        cur_tol               = 512;
        items_sent            = 0;
        moves                 = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero distance at reset settings: short start
        send_beat(CMD_START, POS_MIN, POS_MIN);

        // longest forward move, ends within tolerance, then a tick while idle
        settle_block();
        write_reg(REG_MOVE_DISTANCE, 262143);
        send_beat(CMD_START, 0, 0);
        send_beat(CMD_TICK, 0, 0);
        send_beat(CMD_TICK, 131072, 131071);
        send_beat(CMD_TICK, 262000, 262001);
        send_beat(CMD_TICK, 5, 5);

        // longest reverse move ending on a stall
        settle_block();
        write_reg(REG_MOVE_DISTANCE, -262144);
        send_beat(CMD_START, POS_MAX, POS_MAX);
        send_beat(CMD_TICK, 917000, 917001);
        send_beat(CMD_TICK, 917000, 917001);

        // restart during a move
        send_beat(CMD_START, POS_MAX, POS_MAX - 1);
        send_beat(CMD_TICK, 1000000, 1000000);
        send_beat(CMD_START, POS_MIN, POS_MAX);
        send_beat(CMD_TICK, -300000, -300001);

        // distance cleared during a move ends it at the next tick
        settle_block();
        write_reg(REG_MOVE_DISTANCE, 5000);
        send_beat(CMD_START, 100, 100);
        send_beat(CMD_TICK, 200, 200);
        settle_block();
        write_reg(REG_MOVE_DISTANCE, 0);
        send_beat(CMD_TICK, 300, 300);

        // short starts at the tolerance edge
        settle_block();
        write_reg(REG_DONE_TOLERANCE, 0);
        send_beat(CMD_START, 7, 8);
        settle_block();
        write_reg(REG_DONE_TOLERANCE, 65535);
        write_reg(REG_MOVE_DISTANCE, -65535);
        send_beat(CMD_START, -7, -8);

        // clamp above full drive with maximum gains
        settle_block();
        write_reg(REG_DONE_TOLERANCE, 0);
        write_reg(REG_MAX_POWER, 32767);
        write_reg(REG_P_GAIN, 65535);
        write_reg(REG_D_GAIN, 65535);
        write_reg(REG_STALL_STEP, 65535);
        write_reg(REG_MOVE_DISTANCE, 262143);
        send_beat(CMD_START, POS_MIN, POS_MIN);
        send_beat(CMD_TICK, POS_MIN, POS_MIN);
        send_beat(CMD_TICK, POS_MAX, POS_MAX);

        // zero gains and zero power limit
        settle_block();
        write_reg(REG_P_GAIN, 0);
        write_reg(REG_D_GAIN, 0);
        write_reg(REG_MAX_POWER, 0);
        write_reg(REG_STALL_STEP, 0);
        write_reg(REG_DONE_TOLERANCE, 512);
        write_reg(REG_MOVE_DISTANCE, -40000);
        send_beat(CMD_START, 0, 0);
        send_beat(CMD_TICK, -10000, -10000);
        send_beat(CMD_TICK, -39800, -39800);

        // hold off until the pipeline is empty, then randomize
        settle_block();
        shuffle_gains();
        while (items_sent < ITEM_TARGET) begin
            phase = (items_sent / 150) % 4;
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            if ($urandom_range(9) == 0) begin
                // noise: arbitrary commands and positions
                repeat ($urandom_range(4, 1)) begin
                    send_beat(t_cmd'($urandom_range(1)), $urandom, $urandom);
                    items_sent++;
                end
            end else begin
                drive_move();
            end
            moves++;
            if (moves % 8 == 0) begin
                settle_block();
                shuffle_gains();
            end
        end

        // drain
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (fail_count == 0 && pending_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
